// ===== design/qs_pkg.sv =====
// shared constants, types and arctangent table for the quaternion slerp pipeline
package qs_pkg;

  localparam int CB = 16;
  localparam int FRAC = CB - 1;
  localparam int STEPS = 30;
  localparam int RW = 31;
  localparam int VW = 2 * RW - 1;
  localparam int DW = 32;
  localparam int DOTW = 34;
  localparam int XW = 34;
  localparam int TW = 16;
  localparam int NW = CB + 31;
  localparam int PW = CB + 32;

  localparam int SQRT_LAT = RW;
  localparam int VEC_LAT = STEPS;
  localparam int SIN_LAT = STEPS + 2;
  localparam int DIV_LAT = CB + 1;

  localparam logic [31:0] HALF_PI = 32'h6487ED50;
  localparam logic [32:0] PI_Q30 = 33'h0C90FDAA0;
  localparam logic [31:0] GAIN_INV = 32'h26DD3B6A;
  localparam logic [30:0] ONE_Q30 = 31'h40000000;
  localparam logic [TW-1:0] T_ONE = 16'h8000;
  localparam logic [14:0] THR_RESET = 15'd33;

  typedef struct packed {
    logic [3:0][CB-1:0] qa;
    logic [3:0][CB-1:0] qb;
    logic [TW-1:0]      tf;
  } side_t;

  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h3243F6A8;
      1:  r = 32'h1DAC6705;
      2:  r = 32'h0FADBAFC;
      3:  r = 32'h07F56EA6;
      4:  r = 32'h03FEAB76;
      5:  r = 32'h01FFD55B;
      6:  r = 32'h00FFFAAA;
      7:  r = 32'h007FFF55;
      8:  r = 32'h003FFFEA;
      9:  r = 32'h001FFFFD;
      10: r = 32'h000FFFFF;
      11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;
      13: r = 32'h0001FFFF;
      14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;
      16: r = 32'h00003FFF;
      17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;
      19: r = 32'h000007FF;
      20: r = 32'h000003FF;
      21: r = 32'h000001FF;
      22: r = 32'h000000FF;
      23: r = 32'h0000007F;
      24: r = 32'h0000003F;
      25: r = 32'h0000001F;
      26: r = 32'h0000000F;
      27: r = 32'h00000008;
      28: r = 32'h00000004;
      29: r = 32'h00000002;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/qs_sqrt.sv =====
// pipelined integer square root, one root bit per stage
module qs_sqrt (
  input  logic                   clk_i,
  input  logic [qs_pkg::VW-1:0]  v_i,
  output logic [qs_pkg::RW-1:0]  s_o
);
  import qs_pkg::*;

  logic [VW-1:0] rem_q  [SQRT_LAT];
  logic [RW-1:0] root_q [SQRT_LAT];

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_st
    localparam int B = SQRT_LAT - 1 - k;
    logic [VW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [VW:0]   trial;
    if (k == 0) begin : g_first
      assign rem_in  = v_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end
    assign trial = ((VW+1)'(root_in) << (B + 1)) + ((VW+1)'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if ({1'b0, rem_in} >= trial) begin
        rem_q[k]  <= rem_in - trial[VW-1:0];
        root_q[k] <= root_in | (RW'(1) << B);
      end else begin
        rem_q[k]  <= rem_in;
        root_q[k] <= root_in;
      end
    end
  end

  assign s_o = root_q[SQRT_LAT-1];

endmodule

// ===== design/qs_cordic_vec.sv =====
// pipelined cordic vectoring unit, angle of (cos, sin) in q30 radians
module qs_cordic_vec (
  input  logic                          clk_i,
  input  logic signed [qs_pkg::DW-1:0]  c_i,
  input  logic [qs_pkg::RW-1:0]         s_i,
  output logic signed [qs_pkg::XW-1:0]  z_o
);
  import qs_pkg::*;

  logic signed [XW-1:0] x_q [STEPS];
  logic signed [XW-1:0] y_q [STEPS];
  logic signed [XW-1:0] z_q [STEPS];
  logic signed [XW-1:0] x0, y0, z0;

  // quarter-turn pre-rotation for a negative cosine
  always_comb begin
    if (c_i < 0) begin
      x0 = XW'({1'b0, s_i});
      y0 = -XW'(c_i);
      z0 = $signed(XW'(HALF_PI));
    end else begin
      x0 = XW'(c_i);
      y0 = XW'({1'b0, s_i});
      z0 = '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    logic signed [XW-1:0] x_in, y_in, z_in, at;
    if (k == 0) begin : g_first
      assign x_in = x0;
      assign y_in = y0;
      assign z_in = z0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
    end
    assign at = $signed(XW'(atan_q30(k)));
    always_ff @(posedge clk_i) begin
      if (y_in > 0) begin
        x_q[k] <= x_in + (y_in >>> k);
        y_q[k] <= y_in - (x_in >>> k);
        z_q[k] <= z_in + at;
      end else begin
        x_q[k] <= x_in - (y_in >>> k);
        y_q[k] <= y_in + (x_in >>> k);
        z_q[k] <= z_in - at;
      end
    end
  end

  assign z_o = z_q[STEPS-1];

endmodule

// ===== design/qs_cordic_sin.sv =====
// pipelined cordic rotation unit, sine of a q30 angle in [0, pi]
module qs_cordic_sin (
  input  logic                   clk_i,
  input  logic [31:0]            ang_i,
  output logic [qs_pkg::RW-1:0]  sin_o
);
  import qs_pkg::*;

  logic signed [XW-1:0] zf_q;
  logic signed [XW-1:0] x_q [STEPS];
  logic signed [XW-1:0] y_q [STEPS];
  logic signed [XW-1:0] z_q [STEPS];
  logic [RW-1:0]        sin_q;

  // fold the second quadrant onto the first
  always_ff @(posedge clk_i) begin
    if (ang_i > HALF_PI) begin
      zf_q <= $signed(XW'(PI_Q30) - XW'(ang_i));
    end else begin
      zf_q <= $signed(XW'(ang_i));
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    logic signed [XW-1:0] x_in, y_in, z_in, at;
    if (k == 0) begin : g_first
      assign x_in = $signed(XW'(GAIN_INV));
      assign y_in = '0;
      assign z_in = zf_q;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
    end
    assign at = $signed(XW'(atan_q30(k)));
    always_ff @(posedge clk_i) begin
      if (z_in >= 0) begin
        x_q[k] <= x_in - (y_in >>> k);
        y_q[k] <= y_in + (x_in >>> k);
        z_q[k] <= z_in - at;
      end else begin
        x_q[k] <= x_in + (y_in >>> k);
        y_q[k] <= y_in - (x_in >>> k);
        z_q[k] <= z_in + at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (y_q[STEPS-1] < 0) begin
      sin_q <= '0;
    end else if (y_q[STEPS-1] > $signed(XW'(ONE_Q30))) begin
      sin_q <= ONE_Q30;
    end else begin
      sin_q <= y_q[STEPS-1][RW-1:0];
    end
  end

  assign sin_o = sin_q;

endmodule

// ===== design/qs_div.sv =====
// pipelined restoring divider lane with quotient overflow flag
module qs_div (
  input  logic                   clk_i,
  input  logic [qs_pkg::NW-1:0]  n_i,
  input  logic [qs_pkg::RW-1:0]  d_i,
  output logic                   over_o,
  output logic [qs_pkg::CB-1:0]  q_o
);
  import qs_pkg::*;

  logic [NW-1:0] rem_q [DIV_LAT];
  logic [RW-1:0] d_q   [DIV_LAT];
  logic [CB-1:0] q_q   [DIV_LAT];
  logic          ov_q  [DIV_LAT];

  // quotient does not fit the component width
  always_ff @(posedge clk_i) begin
    rem_q[0] <= n_i;
    d_q[0]   <= d_i;
    q_q[0]   <= '0;
    ov_q[0]  <= (n_i[NW-1:CB] >= d_i);
  end

  for (genvar j = 1; j < DIV_LAT; j++) begin : g_st
    localparam int B = DIV_LAT - 1 - j;
    logic [NW-1:0] sub;
    assign sub = NW'(d_q[j-1]) << B;
    always_ff @(posedge clk_i) begin
      d_q[j]  <= d_q[j-1];
      ov_q[j] <= ov_q[j-1];
      if (rem_q[j-1] >= sub) begin
        rem_q[j] <= rem_q[j-1] - sub;
        q_q[j]   <= q_q[j-1] | (CB'(1) << B);
      end else begin
        rem_q[j] <= rem_q[j-1];
        q_q[j]   <= q_q[j-1];
      end
    end
  end

  assign over_o = ov_q[DIV_LAT-1];
  assign q_o    = q_q[DIV_LAT-1];

endmodule

// ===== design/quaternion_slerp.sv =====
// quaternion slerp top level: dot product, root, angle, sines, blend and select
//
// usage: drive the two quaternions and blend_t with start high for one cycle;
// the transaction is accepted on that edge (busy is always low, so a new
// transaction may be started in every cycle). each result appears on the
// out_*_o ports for exactly one cycle with done_o high, in start order.
// the pipeline from the accepting edge to the edge that takes the
// result holds 3 dot/square stages, 31 root stages, 30 angle stages, 2 angle
// scaling stages, 32 sine stages, 3 blend stages, 17 divide stages and the
// output register. throughput: one transaction per cycle; every stage is
// registered and there is no shared unit.
// the threshold register is written with cfg_we_i/cfg_wdata_i; the user must
// write it only while no transaction is in flight, which the block does not
// enforce; it resets to 33. reset clears the valid chain and sets the
// threshold to 33; transactions in flight are dropped. the receiver cannot stall the output.
module quaternion_slerp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [14:0]                   cfg_wdata_i,
  input  logic signed [qs_pkg::CB-1:0]  first_w_i,
  input  logic signed [qs_pkg::CB-1:0]  first_x_i,
  input  logic signed [qs_pkg::CB-1:0]  first_y_i,
  input  logic signed [qs_pkg::CB-1:0]  first_z_i,
  input  logic signed [qs_pkg::CB-1:0]  second_w_i,
  input  logic signed [qs_pkg::CB-1:0]  second_x_i,
  input  logic signed [qs_pkg::CB-1:0]  second_y_i,
  input  logic signed [qs_pkg::CB-1:0]  second_z_i,
  input  logic [qs_pkg::TW-1:0]         blend_t_i,
  output logic                          done_o,
  output logic signed [qs_pkg::CB-1:0]  out_w_o,
  output logic signed [qs_pkg::CB-1:0]  out_x_o,
  output logic signed [qs_pkg::CB-1:0]  out_y_o,
  output logic signed [qs_pkg::CB-1:0]  out_z_o
);
  import qs_pkg::*;

  localparam int P3   = 3;
  localparam int PS   = P3 + SQRT_LAT;
  localparam int PZ   = PS + VEC_LAT;
  localparam int PTH  = PZ + 1;
  localparam int PANG = PTH + 1;
  localparam int PSN  = PANG + SIN_LAT;
  localparam int PPR  = PSN + 1;
  localparam int PNM  = PPR + 1;
  localparam int PDV  = PNM + 1;
  localparam int PQ   = PDV + DIV_LAT;
  localparam int POUT = PQ + 1;
  localparam int PSH  = 2 * FRAC - 30;

  localparam logic [CB-1:0] MAX_POS = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] MIN_NEG = {1'b1, {(CB-1){1'b0}}};

  logic [POUT:1]   vld_q;
  logic [14:0]     thr_q;
  side_t           side_q [1:PQ];
  side_t           side_in;
  logic signed [CB-1:0] ain [4];
  logic signed [CB-1:0] bin [4];
  logic signed [31:0]   prod_q [4];
  logic signed [DOTW-1:0] dot_q [2:PS];
  logic            uni_q [P3:PQ];
  logic [VW-1:0]   v_q;
  logic [RW-1:0]   s_root;
  logic [RW-1:0]   s_q [PS+1:PQ];
  logic signed [XW-1:0] z_vec;
  logic [31:0]     theta_q;
  logic [31:0]     anga_q, angb_q;
  logic [RW-1:0]   sin_a, sin_b;
  logic signed [PW-1:0] pa_q [4];
  logic signed [PW-1:0] pb_q [4];
  logic signed [PW:0]   num_q [4];
  logic [NW-1:0]   n_q [4];
  logic [3:0]      neg_q [PDV:PQ];
  logic [3:0]      over;
  logic [CB-1:0]   quo [4];
  logic [3:0][CB-1:0] out_q;
  logic            avg_sel;

  assign busy = 1'b0;

  assign ain[0] = first_w_i;
  assign ain[1] = first_x_i;
  assign ain[2] = first_y_i;
  assign ain[3] = first_z_i;
  assign bin[0] = second_w_i;
  assign bin[1] = second_x_i;
  assign bin[2] = second_y_i;
  assign bin[3] = second_z_i;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      side_in.qa[k] = ain[k];
      side_in.qb[k] = bin[k];
    end
    side_in.tf = (blend_t_i > T_ONE) ? T_ONE : blend_t_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      thr_q <= THR_RESET;
    end else begin
      vld_q <= {vld_q[POUT-1:1], start & ~busy};
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // sideband delay lines
  always_ff @(posedge clk_i) begin
    side_q[1] <= side_in;
    for (int k = 2; k <= PQ; k++) begin
      side_q[k] <= side_q[k-1];
    end
    s_q[PS+1] <= s_root;
    for (int k = PS + 2; k <= PQ; k++) begin
      s_q[k] <= s_q[k-1];
    end
  end

  for (genvar k = 3; k <= PS; k++) begin : g_dot_dly
    always_ff @(posedge clk_i) begin
      dot_q[k] <= dot_q[k-1];
    end
  end

  for (genvar k = P3 + 1; k <= PQ; k++) begin : g_uni_dly
    always_ff @(posedge clk_i) begin
      uni_q[k] <= uni_q[k-1];
    end
  end

  for (genvar k = PDV + 1; k <= PQ; k++) begin : g_neg_dly
    always_ff @(posedge clk_i) begin
      neg_q[k] <= neg_q[k-1];
    end
  end

  // dot product in q30
  for (genvar k = 0; k < 4; k++) begin : g_prod
    logic signed [2*CB-1:0] p;
    logic signed [63:0]     pw;
    assign p  = ain[k] * bin[k];
    assign pw = 64'(p);
    always_ff @(posedge clk_i) begin
      if (PSH > 0) begin
        prod_q[k] <= 32'(pw >>> ((PSH > 0) ? PSH : 0));
      end else begin
        prod_q[k] <= 32'(pw <<< ((PSH > 0) ? 0 : -PSH));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dot_q[2] <= DOTW'(prod_q[0]) + DOTW'(prod_q[1]) + DOTW'(prod_q[2]) + DOTW'(prod_q[3]);
  end

  // 1 - dot^2 in q60 and the unity check
  always_ff @(posedge clk_i) begin
    logic signed [30:0] d31;
    logic signed [61:0] sq;
    d31 = dot_q[2][30:0];
    sq  = d31 * d31;
    v_q <= (VW'(1) << 60) - VW'(sq[59:0]);
    uni_q[P3] <= (dot_q[2] >= $signed(DOTW'(ONE_Q30))) ||
                 (dot_q[2] <= -$signed(DOTW'(ONE_Q30)));
  end

  qs_sqrt u_sqrt (
    .clk_i (clk_i),
    .v_i   (v_q),
    .s_o   (s_root)
  );

  qs_cordic_vec u_vec (
    .clk_i (clk_i),
    .c_i   (dot_q[PS][DW-1:0]),
    .s_i   (s_root),
    .z_o   (z_vec)
  );

  // clamp theta to [0, pi], then scale by (1-t) and t
  always_ff @(posedge clk_i) begin
    if (z_vec < 0) begin
      theta_q <= '0;
    end else if (z_vec > $signed(XW'(PI_Q30))) begin
      theta_q <= PI_Q30[31:0];
    end else begin
      theta_q <= z_vec[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    logic [47:0] ma, mb;
    ma = 48'(theta_q) * 48'(T_ONE - side_q[PTH].tf);
    mb = 48'(theta_q) * 48'(side_q[PTH].tf);
    anga_q <= ma[46:15];
    angb_q <= mb[46:15];
  end

  qs_cordic_sin u_sin_a (
    .clk_i (clk_i),
    .ang_i (anga_q),
    .sin_o (sin_a)
  );

  qs_cordic_sin u_sin_b (
    .clk_i (clk_i),
    .ang_i (angb_q),
    .sin_o (sin_b)
  );

  // weighted sum, magnitude plus half divisor, then divide
  for (genvar k = 0; k < 4; k++) begin : g_lane
    always_ff @(posedge clk_i) begin
      pa_q[k]  <= $signed(side_q[PSN].qa[k]) * $signed({1'b0, sin_a});
      pb_q[k]  <= $signed(side_q[PSN].qb[k]) * $signed({1'b0, sin_b});
      num_q[k] <= (PW+1)'(pa_q[k]) + (PW+1)'(pb_q[k]);
    end

    always_ff @(posedge clk_i) begin
      logic [PW:0] mag;
      mag = num_q[k][PW] ? -num_q[k] : num_q[k];
      n_q[k]          <= mag[NW-1:0] + NW'(s_q[PNM] >> 1);
      neg_q[PDV][k]   <= num_q[k][PW];
    end

    qs_div u_div (
      .clk_i  (clk_i),
      .n_i    (n_q[k]),
      .d_i    (s_q[PDV]),
      .over_o (over[k]),
      .q_o    (quo[k])
    );
  end

  // result select and saturation
  assign avg_sel = s_q[PQ] < RW'({thr_q, 15'd0});

  always_ff @(posedge clk_i) begin
    logic [CB:0] sum;
    for (int k = 0; k < 4; k++) begin
      sum = (CB+1)'($signed(side_q[PQ].qa[k])) + (CB+1)'($signed(side_q[PQ].qb[k]));
      if (uni_q[PQ]) begin
        out_q[k] <= side_q[PQ].qa[k];
      end else if (avg_sel) begin
        out_q[k] <= sum[CB:1];
      end else if (!neg_q[PQ][k]) begin
        out_q[k] <= (over[k] || quo[k][CB-1]) ? MAX_POS : quo[k];
      end else begin
        out_q[k] <= (over[k] || quo[k] > MIN_NEG) ? MIN_NEG : -quo[k];
      end
    end
  end

  assign done_o  = vld_q[POUT];
  assign out_w_o = out_q[0];
  assign out_x_o = out_q[1];
  assign out_y_o = out_q[2];
  assign out_z_o = out_q[3];

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the quaternion slerp pipeline with its own fixed-point predictor
module tb;
  import qs_pkg::*;

  typedef struct packed {
    logic [3:0][CB-1:0] qa;
    logic [3:0][CB-1:0] qb;
    logic [TW-1:0]      tf;
  } pair_t;

  typedef logic [3:0][CB-1:0] quat_t;

  localparam longint ONE30 = longint'(1) << 30;
  localparam longint GAIN = 64'h26DD3B6A;
  localparam longint ARCTAN [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;
  pair_t drv = '0;
  logic done_o;
  logic signed [CB-1:0] out_w_o, out_x_o, out_y_o, out_z_o;

  pair_t pending_pairs[$];
  quat_t expected_quats[$];
  logic [14:0] sine_threshold = THR_RESET;
  int idle_pct = 37;
  int errors = 0;
  logic accepted = 1'b0;

  quaternion_slerp dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_wdata_i,
    .first_w_i(drv.qa[0]), .first_x_i(drv.qa[1]), .first_y_i(drv.qa[2]),
    .first_z_i(drv.qa[3]), .second_w_i(drv.qb[0]), .second_x_i(drv.qb[1]),
    .second_y_i(drv.qb[2]), .second_z_i(drv.qb[3]), .blend_t_i(drv.tf),
    .done_o, .out_w_o, .out_x_o, .out_y_o, .out_z_o
  );

  always #5 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint angle_from(longint c, longint s);
    longint x, y, z, nx, ny;
    if (c < 0) begin
      x = s; y = -c; z = 2 * ARCTAN[0];
    end else begin
      x = c; y = s; z = 0;
    end
    for (int i = 0; i < 30; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN[i];
      end
      x = nx; y = ny;
    end
    if (z < 0) z = 0;
    if (z > 4 * ARCTAN[0]) z = 4 * ARCTAN[0];
    return z;
  endfunction

  function automatic longint sine_from(longint ang);
    longint x, y, z, nx, ny;
    x = GAIN; y = 0;
    if (ang > 2 * ARCTAN[0]) ang = 4 * ARCTAN[0] - ang;
    z = ang;
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN[i];
      end
      x = nx; y = ny;
    end
    if (y < 0) y = 0;
    if (y > ONE30) y = ONE30;
    return y;
  endfunction

  function automatic quat_t slerp_predict(pair_t p, logic [14:0] thr);
    longint a[4], b[4], dot, s, theta, sa, sb, num, q, t;
    longint unsigned mag;
    quat_t r;
    dot = 0;
    for (int k = 0; k < 4; k++) begin
      a[k] = longint'($signed(p.qa[k]));
      b[k] = longint'($signed(p.qb[k]));
      dot += a[k] * b[k];
    end
    t = (p.tf > T_ONE) ? 32768 : longint'(p.tf);
    if (dot >= ONE30 || dot <= -ONE30) begin
      r = p.qa;
    end else begin
      s = longint'(int_sqrt((longint'(1) << 60) - dot * dot));
      if (s < (longint'(thr) << 15)) begin
        for (int k = 0; k < 4; k++) r[k] = CB'((a[k] + b[k]) >>> 1);
      end else begin
        theta = angle_from(dot, s);
        sa = sine_from((theta * (32768 - t)) >>> 15);
        sb = sine_from((theta * t) >>> 15);
        for (int k = 0; k < 4; k++) begin
          num = a[k] * sa + b[k] * sb;
          mag = (num < 0) ? -num : num;
          q = longint'((mag + longint'(s) / 2) / longint'(s));
          if (num < 0) q = -q;
          if (q > 32767) q = 32767;
          if (q < -32768) q = -32768;
          r[k] = CB'(q);
        end
      end
    end
    return r;
  endfunction

  // driver: holds start until the transaction is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!start || accepted)) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        drv <= pending_pairs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    quat_t exp_q;
    quat_t got;
    accepted = start && !busy;
    if (accepted) expected_quats.push_back(slerp_predict(drv, sine_threshold));
    if (done_o) begin
      got = {out_z_o, out_y_o, out_x_o, out_w_o};
      if (expected_quats.size() == 0) begin
        $error("unexpected transaction out=%h", got);
        errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (got[0] !== exp_q[0]) begin
          $error("out_w expected %0d actual %0d", $signed(exp_q[0]), $signed(got[0]));
          errors++;
        end
        if (got[1] !== exp_q[1]) begin
          $error("out_x expected %0d actual %0d", $signed(exp_q[1]), $signed(got[1]));
          errors++;
        end
        if (got[2] !== exp_q[2]) begin
          $error("out_y expected %0d actual %0d", $signed(exp_q[2]), $signed(got[2]));
          errors++;
        end
        if (got[3] !== exp_q[3]) begin
          $error("out_z expected %0d actual %0d", $signed(exp_q[3]), $signed(got[3]));
          errors++;
        end
      end
    end
  end

  function automatic logic [TW-1:0] rand_blend();
    if ($urandom_range(9) == 0) return TW'($urandom_range(65535));
    if ($urandom_range(9) == 0) return $urandom_range(1) ? T_ONE : '0;
    return TW'($urandom_range(32768));
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int sel;
    sel = $urandom_range(9);
    for (int k = 0; k < 4; k++) begin
      if (sel < 3) begin
        p.qa[k] = CB'($urandom_range(65535));
        p.qb[k] = CB'($urandom_range(65535));
      end else begin
        p.qa[k] = CB'(int'($urandom_range(32767)) - 16384);
        if (sel < 6) p.qb[k] = CB'(int'($urandom_range(32767)) - 16384);
        else p.qb[k] = CB'($signed(p.qa[k]) + int'($urandom_range(64)) - 32);
      end
    end
    if (sel == 9) p.qb = p.qa;
    p.tf = rand_blend();
    return p;
  endfunction

  function automatic pair_t mk(quat_t a, quat_t b, logic [TW-1:0] t);
    pair_t p;
    p.qa = a; p.qb = b; p.tf = t;
    return p;
  endfunction

  task automatic drain();
    wait (pending_pairs.size() == 0);
    @(posedge clk_i);
    while (start || expected_quats.size() > 0) @(posedge clk_i);
    repeat (130) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [14:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sine_threshold = v;
  endtask

  initial begin
    logic [14:0] settings[5];
    settings = '{THR_RESET, 15'd0, 15'd32767, 15'd1000, 15'd5};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    pending_pairs.push_back(mk({4{16'h7FFF}}, {4{16'h7FFF}}, T_ONE));
    pending_pairs.push_back(mk({4{16'h8000}}, {4{16'h8000}}, '0));
    pending_pairs.push_back(mk({4{16'h8000}}, {4{16'h7FFF}}, 16'hFFFF));
    pending_pairs.push_back(mk('0, '0, 16'h4000));
    pending_pairs.push_back(mk({48'h0, 16'h8000}, {48'h0, 16'h8000}, 16'h4000));
    pending_pairs.push_back(mk({48'h0, 16'h7FFF}, {48'h0, 16'h7FFF}, 16'h2000));
    pending_pairs.push_back(mk({48'h0, 16'h7FFF}, {48'h0, 16'h8001}, 16'h6000));
    pending_pairs.push_back(mk({48'h0, 16'h7FFF}, {32'h0, 16'h7FFF, 16'h0}, '0));
    pending_pairs.push_back(mk({48'h0, 16'h7FFF}, {32'h0, 16'h7FFF, 16'h0}, T_ONE));
    pending_pairs.push_back(mk({48'h0, 16'h7FFF}, {32'h0, 16'h7FFF, 16'h0}, 16'h8001));
    pending_pairs.push_back(mk({48'h0, 16'h7FFF}, {32'h0, 16'h5A82, 16'h5A82}, 16'h4000));
    pending_pairs.push_back(mk({48'h0, 16'h7FFF}, {32'h0, 16'hA57E, 16'hA57E}, 16'h1234));
    pending_pairs.push_back(mk({4{16'h4000}}, {4{16'h4000}}, 16'h4000));
    pending_pairs.push_back(mk({4{16'h4000}}, {16'h4000, 16'h4000, 16'h4000, 16'h3FF0}, 16'h7000));
    pending_pairs.push_back(mk({4{16'h4000}}, {16'hC000, 16'h4000, 16'hC000, 16'h4000}, 16'h0001));
    pending_pairs.push_back(mk({4{16'h7FFF}}, {4{16'h8000}}, 16'h7FFF));
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_threshold(settings[ph]);
      case (ph % 3)
        0: idle_pct = 37;
        1: idle_pct = 65;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 370; n++) pending_pairs.push_back(rand_pair());
      drain();
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
